@@ design/uvs_pkg.sv @@
// Shared types, constants and helper functions for the UV sphere vertex generator.
`timescale 1ns / 1ps
package uvs_pkg;

	// divider: numerator is at most index << 32 plus a rounding term, denominator up to 2*255
	localparam int NUM_W      = 40;
	localparam int DEN_W      = 9;
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = NUM_W / DIV_STEP;

	// CORDIC datapath, Q2.30 with headroom
	localparam int CW = 34;
	localparam logic [CW-1:0] INV_GAIN = CW'(652032874);

	// atan(2^-i) in phase units, 2^32 per turn
	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	typedef enum logic {
		REG_RING_COUNT    = 1'b0,
		REG_SEGMENT_COUNT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] quo;
		logic [DEN_W-1:0] rem;
		logic [DEN_W-1:0] den;
	} div_st_t;

	typedef struct packed {
		logic [1:0]          quad;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cordic_st_t;

	typedef struct packed {
		logic [15:0] ia;
		logic [15:0] ib;
		logic        iv;
		logic        oor;
	} side_t;

	typedef struct packed {
		logic [15:0] tu;
		logic [15:0] tv;
	} tex_t;

	// DIV_STEP restoring division steps
	function automatic div_st_t div_step(div_st_t a);
		div_st_t r;
		logic [DEN_W:0] t;
		r = a;
		for (int j = 0; j < DIV_STEP; j++) begin
			t = {r.rem, r.num[NUM_W-1]};
			r.num = {r.num[NUM_W-2:0], 1'b0};
			if (t >= {1'b0, r.den}) begin
				t = t - {1'b0, r.den};
				r.quo = {r.quo[NUM_W-2:0], 1'b1};
			end else begin
				r.quo = {r.quo[NUM_W-2:0], 1'b0};
			end
			r.rem = t[DEN_W-1:0];
		end
		return r;
	endfunction

	// round to nearest, ties away from zero, then saturate to 16 bits signed
	function automatic logic [15:0] round_sat(logic signed [65:0] v, int unsigned sh);
		logic [66:0] w;
		logic signed [66:0] t;
		w = {v, 1'b0} + (67'd1 << sh) - 67'(v[65]);
		t = $signed(w) >>> (sh + 1);
		if (t > 67'sd32767)
			return 16'h7FFF;
		else if (t < -67'sd32768)
			return 16'h8000;
		else
			return t[15:0];
	endfunction

endpackage

@@ design/uvs_div.sv @@
// Pipelined restoring divider, DIV_STEP quotient bits per stage.
`timescale 1ns / 1ps
module uvs_div
	import uvs_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);

	div_st_t st_s [DIV_STAGES];
	div_st_t first;

	assign first = '{num: num, quo: '0, rem: '0, den: den};

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= div_step(first);
			for (int k = 1; k < DIV_STAGES; k++)
				st_s[k] <= div_step(st_s[k-1]);
		end
	end

	assign quo = st_s[DIV_STAGES-1].quo;

endmodule

@@ design/uvs_cordic.sv @@
// Pipelined rotation-mode CORDIC: phase in, cosine and sine in Q30 out.
`timescale 1ns / 1ps
module uvs_cordic
	import uvs_pkg::*;
#(
	parameter int STAGES = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [31:0]          phase,
	output logic signed [CW-1:0] cos_val,
	output logic signed [CW-1:0] sin_val
);

	localparam int N = (STAGES > 32) ? 32 : STAGES;
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;

	function automatic cordic_st_t iter(cordic_st_t a, int i);
		cordic_st_t r;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] at;
		r  = a;
		dx = a.y >>> i;
		dy = a.x >>> i;
		at = $signed(CW'(ATAN_TURNS[i]));
		if (!a.z[CW-1]) begin
			r.x = a.x - dx;
			r.y = a.y + dy;
			r.z = a.z - at;
		end else begin
			r.x = a.x + dx;
			r.y = a.y - dy;
			r.z = a.z + at;
		end
		return r;
	endfunction

	cordic_st_t init;
	cordic_st_t it_s [N];

	assign init = '{quad: phase[31:30], x: $signed(INV_GAIN), y: '0,
		z: $signed(CW'(phase[29:0]))};

	always_ff @(posedge clk) begin
		if (en) begin
			it_s[0] <= iter(init, 0);
			for (int k = 1; k < N; k++)
				it_s[k] <= iter(it_s[k-1], k);
		end
	end

	// quadrant fold-back
	always_ff @(posedge clk) begin
		if (en) begin
			case (it_s[N-1].quad)
				QUAD_0: begin
					cos_val <= it_s[N-1].x;
					sin_val <= it_s[N-1].y;
				end
				QUAD_1: begin
					cos_val <= -it_s[N-1].y;
					sin_val <= it_s[N-1].x;
				end
				QUAD_2: begin
					cos_val <= -it_s[N-1].x;
					sin_val <= -it_s[N-1].y;
				end
				default: begin
					cos_val <= it_s[N-1].y;
					sin_val <= -it_s[N-1].x;
				end
			endcase
		end
	end

endmodule

@@ design/uv_sphere_vertex_generator_core.sv @@
// Top level of the UV sphere vertex generator: config, pipeline control, output assembly.
`timescale 1ns / 1ps
// Usage
//   Input stream (s_*): one beat per grid point (ring, segment).
//   Output stream (m_*): one beat per input beat, same order: position
//   (Q1.15 signed), texture coordinates (Q1.15 unsigned), strip indices
//   and two flags in m_tuser.
//   Config port: cfg_we/cfg_index/cfg_data; user writes it only while idle, unchecked.
//   ring_count and segment_count reset to 16; a zero count acts as one.
// Pipeline, input beat to output beat: 1 input stage, 10 divider stages,
//   CORDIC_STAGES + 1 CORDIC stages, 1 multiply stage, 1 round/saturate
//   output register.
// Throughput: one beat per cycle unless the output stalls; set by the fully
//   pipelined divider and CORDIC lanes, taking a new operand every unstalled cycle.
// Stall: the whole pipe holds while the output beat waits; s_tready is
//   low only when the output register is full and m_tready is low.
// Reset: arst_n clears valid bits and resets config to 16; the pipe comes up empty.
module uv_sphere_vertex_generator_core
	import uvs_pkg::*;
#(
	parameter int FRAC_BITS     = 15,
	parameter int CORDIC_STAGES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,   // ring[7:0], segment[15:8]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v,
	                                // strip_index_a, strip_index_b (16 bits each)
	output logic [1:0]   m_tuser,   // indices_valid[0], out_of_range[1]
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [7:0]   cfg_data
);

	localparam int CS     = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam int L      = CS + 14;
	localparam int SIDE_D = L - 2;
	localparam int TEX_D  = CS + 2;

	logic [7:0] ring_count_q, segment_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_count_q    <= 8'd16;
			segment_count_q <= 8'd16;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_RING_COUNT:    ring_count_q    <= cfg_data;
				REG_SEGMENT_COUNT: segment_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic         en;
	logic [L-1:0] vld_q;

	assign en       = !vld_q[L-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[L-2:0], s_tvalid};
	end

	// input stage: counts, numerators, flags, strip indices
	logic [7:0]  ring, seg, rc, sc;
	logic [17:0] lin;
	logic [15:0] ia, ib;
	side_t       side_c;

	assign ring = s_tdata[7:0];
	assign seg  = s_tdata[15:8];
	assign rc   = (ring_count_q == 8'd0) ? 8'd1 : ring_count_q;
	assign sc   = (segment_count_q == 8'd0) ? 8'd1 : segment_count_q;
	assign lin  = 18'(ring) * (18'(sc) + 18'd1) + 18'(seg);
	assign ia   = lin[15:0];
	assign ib   = ia + 16'(sc) + 16'd1;

	always_comb begin
		side_c.iv  = ring < rc;
		side_c.oor = (ring > rc) || (seg > sc);
		side_c.ia  = side_c.iv ? ia : 16'd0;
		side_c.ib  = side_c.iv ? ib : 16'd0;
	end

	logic [NUM_W-1:0] nr_s1, ns_s1, nu_s1, nv_s1;
	logic [DEN_W-1:0] dr_s1, dsg_s1, drc_s1;
	side_t            side_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			nr_s1   <= {ring, 32'd0} + NUM_W'(rc);
			ns_s1   <= {seg, 32'd0} + NUM_W'(sc >> 1);
			nv_s1   <= (NUM_W'(ring) << FRAC_BITS) + NUM_W'(rc >> 1);
			// negative u clamps to zero, same as a zero numerator
			nu_s1   <= (sc >= seg) ? (NUM_W'(sc - seg) << FRAC_BITS) + NUM_W'(sc >> 1)
				: '0;
			dr_s1   <= {rc, 1'b0};
			dsg_s1  <= {1'b0, sc};
			drc_s1  <= {1'b0, rc};
			side_s1 <= side_c;
		end
	end

	// dividers: ring phase, segment phase, tex_u, tex_v
	logic [NUM_W-1:0] qr, qs, qu, qv;

	uvs_div u_div_ring (.clk(clk), .en(en), .num(nr_s1), .den(dr_s1),  .quo(qr));
	uvs_div u_div_seg  (.clk(clk), .en(en), .num(ns_s1), .den(dsg_s1), .quo(qs));
	uvs_div u_div_u    (.clk(clk), .en(en), .num(nu_s1), .den(dsg_s1), .quo(qu));
	uvs_div u_div_v    (.clk(clk), .en(en), .num(nv_s1), .den(drc_s1), .quo(qv));

	tex_t tex_c;
	assign tex_c.tu = (qu[NUM_W-1:16] != '0) ? 16'hFFFF : qu[15:0];
	assign tex_c.tv = (qv[NUM_W-1:16] != '0) ? 16'hFFFF : qv[15:0];

	// CORDIC lanes
	logic signed [CW-1:0] yc, rs, scos, ssin;

	uvs_cordic #(.STAGES(CS)) u_cordic_ring (
		.clk(clk), .en(en), .phase(qr[31:0]), .cos_val(yc), .sin_val(rs));
	uvs_cordic #(.STAGES(CS)) u_cordic_seg (
		.clk(clk), .en(en), .phase(qs[31:0]), .cos_val(scos), .sin_val(ssin));

	// sideband delay lines
	side_t side_q [SIDE_D];
	tex_t  tex_q  [TEX_D];

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s1;
			for (int i = 1; i < SIDE_D; i++)
				side_q[i] <= side_q[i-1];
			tex_q[0] <= tex_c;
			for (int i = 1; i < TEX_D; i++)
				tex_q[i] <= tex_q[i-1];
		end
	end

	// multiply stage: radius times azimuth sine/cosine, Q60
	logic signed [63:0]   px_sm, pz_sm;
	logic signed [CW-1:0] yc_sm;

	always_ff @(posedge clk) begin
		if (en) begin
			px_sm <= $signed(rs[31:0]) * $signed(ssin[31:0]);
			pz_sm <= $signed(rs[31:0]) * $signed(scos[31:0]);
			yc_sm <= yc;
		end
	end

	// output register: round, saturate, assemble
	logic [15:0] px_o, py_o, pz_o;
	side_t       side_o;
	tex_t        tex_o;

	always_ff @(posedge clk) begin
		if (en) begin
			px_o   <= round_sat({{2{px_sm[63]}}, px_sm}, 60 - FRAC_BITS);
			pz_o   <= round_sat({{2{pz_sm[63]}}, pz_sm}, 60 - FRAC_BITS);
			py_o   <= round_sat({{(66-CW){yc_sm[CW-1]}}, yc_sm}, 30 - FRAC_BITS);
			side_o <= side_q[SIDE_D-1];
			tex_o  <= tex_q[TEX_D-1];
		end
	end

	assign m_tdata = {side_o.ib, side_o.ia, tex_o.tv, tex_o.tu, pz_o, py_o, px_o};
	assign m_tuser = {side_o.oor, side_o.iv};

endmodule

@@ design/uvs_checker.sv @@
// Port-level checker for the UV sphere vertex generator, bound to the top level.
`timescale 1ns / 1ps
module uvs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [111:0] m_tdata,
	input logic [1:0]   m_tuser
);

	// empty pipe while in reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output beat valid during reset");

	// input side only stalls when the output beat is held
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow output stall");

	// held beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output beat changed");

	// no strip indices without indices_valid (last ring and beyond)
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[111:80] == 32'd0)
		else $error("strip indices nonzero without indices_valid");

endmodule

bind uv_sphere_vertex_generator_core uvs_checker u_uvs_checker (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
	.m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser));

@@ sim/tb_top.sv @@
// Self-checking testbench for the UV sphere vertex generator core.
`timescale 1ns / 1ps
module tb_top;
	import uvs_pkg::*;

	localparam int PIPE_LAT = 16 + 14;	// input beat to output beat, default build

	typedef struct {
		logic [15:0] px, py, pz, tu, tv, ia, ib;
		logic        iv, oor;
	} vertex_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [15:0]  s_tdata;	// ring[7:0], segment[15:8]
	logic         m_tvalid;
	logic         m_tready;
	logic [111:0] m_tdata;	// pos_x, pos_y, pos_z, tex_u, tex_v, strip_index_a, strip_index_b
	logic [1:0]   m_tuser;	// indices_valid[0], out_of_range[1]
	logic         cfg_we;
	logic [0:0]   cfg_index;
	logic [7:0]   cfg_data;

	// Local copy of the two count registers
	logic [7:0] rings_cfg;
	logic [7:0] segs_cfg;

	logic [15:0] grid_points [$];	// beats waiting to be sent
	vertex_t     vertex_fifo [$];	// expected vertices, oldest first
	int          errors;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	uv_sphere_vertex_generator_core uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("TEST FAILED");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Rotation-mode CORDIC on a 2^32-per-turn phase; cosine and sine in Q30
	function automatic void cordic_sin_cos(input logic [31:0] phase, output longint c,
			output longint s);
		longint x, y, z, dx, dy;
		x = 652032874;
		y = 0;
		z = longint'(phase & 32'h3FFF_FFFF);
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
			end
		end
		case (phase[31:30])
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y;  s = -x; end
		endcase
	endfunction

	// nearest, ties away from zero
	function automatic longint rnd_shift(input longint v, input int sh);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (longint'(1) << (sh - 1))) >> sh;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint rnd_div(input longint num, input longint den);
		longint m;
		m = (num < 0) ? -num : num;
		m = (m + den / 2) / den;
		return (num < 0) ? -m : m;
	endfunction

	function automatic logic [15:0] sat16s(input longint v);
		return (v > 32767) ? 16'h7FFF : (v < -32768) ? 16'h8000 : v[15:0];
	endfunction

	function automatic logic [15:0] sat16u(input longint v);
		return (v > 65535) ? 16'hFFFF : (v < 0) ? 16'h0000 : v[15:0];
	endfunction

	function automatic vertex_t sphere_vertex(input logic [7:0] ring, input logic [7:0] seg);
		vertex_t     r;
		logic [63:0] rc, sc, ring_ph, seg_ph;
		longint      yc, rs, sc_cos, sc_sin;
		rc = (rings_cfg == 0) ? 64'd1 : 64'(rings_cfg);	// zero count acts as one
		sc = (segs_cfg == 0) ? 64'd1 : 64'(segs_cfg);
		ring_ph = ((64'(ring) << 32) + rc) / (2 * rc);
		seg_ph = ((64'(seg) << 32) + sc / 2) / sc;
		cordic_sin_cos(ring_ph[31:0], yc, rs);
		cordic_sin_cos(seg_ph[31:0], sc_cos, sc_sin);
		r.px = sat16s(rnd_shift(rs * sc_sin, 45));
		r.pz = sat16s(rnd_shift(rs * sc_cos, 45));
		r.py = sat16s(rnd_shift(yc, 15));
		r.tu = sat16u(rnd_div((longint'(sc) - longint'(seg)) * 32768, longint'(sc)));
		r.tv = sat16u(rnd_div(longint'(ring) * 32768, longint'(rc)));
		r.iv = (64'(ring) < rc);
		r.oor = (64'(ring) > rc) || (64'(seg) > sc);
		r.ia = '0;
		r.ib = '0;
		if (r.iv) begin
			r.ia = 16'(64'(ring) * (sc + 1) + 64'(seg));
			r.ib = 16'(64'(r.ia) + sc + 1);
		end
		return r;
	endfunction

	// Sender: holds the beat until taken, random gaps between beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				vertex_fifo.push_back(sphere_vertex(s_tdata[7:0], s_tdata[15:8]));
			if (grid_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= grid_points.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, checks every output beat
	always @(posedge clk or negedge arst_n) begin
		vertex_t e;
		logic [15:0] got [9];
		logic [15:0] want [9];
		string names [9];
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (vertex_fifo.size() == 0) begin
					report_mismatch("output beat with nothing expected");
				end else begin
					e = vertex_fifo.pop_front();
					names = '{"pos_x", "pos_y", "pos_z", "tex_u", "tex_v",
						"strip_index_a", "strip_index_b", "indices_valid", "out_of_range"};
					want = '{e.px, e.py, e.pz, e.tu, e.tv, e.ia, e.ib,
						16'(e.iv), 16'(e.oor)};
					for (int k = 0; k < 7; k++)
						got[k] = m_tdata[16*k +: 16];
					got[7] = 16'(m_tuser[0]);
					got[8] = 16'(m_tuser[1]);
					for (int k = 0; k < 9; k++)
						if (got[k] !== want[k])
							report_mismatch($sformatf("%s got %h want %h (rc %0d sc %0d)",
								names[k], got[k], want[k], rings_cfg, segs_cfg));
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic drain();
		while (grid_points.size() != 0 || s_tvalid || vertex_fifo.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	task automatic write_count(input reg_idx_t idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RING_COUNT)
			rings_cfg = val;
		else
			segs_cfg = val;
	endtask

	task automatic add_point(input int ring, input int seg);
		grid_points.push_back({seg[7:0], ring[7:0]});
	endtask

	initial begin
		int rcs [9];
		int scs [9];
		int rc, sc;
		rcs = '{16, 1, 255, 0, 255, 1, 7, 200, 3};
		scs = '{16, 1, 255, 0, 1, 255, 12, 33, 255};
		errors = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_RING_COUNT;
		cfg_data = '0;
		send_idle_pct = 35;
		recv_idle_pct = 59;
		rings_cfg = 8'd16;	// reset values
		segs_cfg = 8'd16;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed corners at reset counts: poles, seam, last ring, out of range
		add_point(0, 0);	add_point(16, 16);	add_point(16, 0);	add_point(0, 16);
		add_point(8, 8);	add_point(8, 4);	add_point(4, 12);	add_point(15, 15);
		add_point(15, 16);	add_point(17, 3);	add_point(3, 17);	add_point(255, 255);
		add_point(0, 255);	add_point(255, 0);	add_point(12, 2);	add_point(1, 1);
		add_point(170, 85);	add_point(85, 170);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			// idle pattern cycles: sender-heavy, receiver-heavy, none
			case (ph % 3)
				0: begin send_idle_pct = 35; recv_idle_pct = 59; end
				1: begin send_idle_pct = 59; recv_idle_pct = 35; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			write_count(REG_RING_COUNT, rcs[ph][7:0]);
			write_count(REG_SEGMENT_COUNT, scs[ph][7:0]);
			rc = (rcs[ph] == 0) ? 1 : rcs[ph];
			sc = (scs[ph] == 0) ? 1 : scs[ph];
			add_point(0, 0);
			add_point(rc, sc);
			add_point(rc - 1, sc);
			for (int n = 0; n < 180; n++) begin
				if ($urandom_range(99) < 80)
					add_point($urandom_range(rc), $urandom_range(sc));
				else
					add_point($urandom_range(255), $urandom_range(255));
			end
			drain();	// sender holds off until every vertex is back
		end

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
design/uvs_pkg.sv
design/uvs_div.sv
design/uvs_cordic.sv
design/uv_sphere_vertex_generator_core.sv
design/uvs_checker.sv
sim/tb_top.sv
